### design/dmacrb_pkg.sv
`timescale 1ns / 1ps

package dmacrb_pkg;

  localparam int CHANNELS_DEF = 8;
  localparam int CHAN_WINDOW_SLOTS = 8;
  localparam int REGS_PER_CHAN = 13;
  localparam int NUM_SETS = 5;
  localparam int SET_W = 8;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 10;
  localparam int CH_W = 3;
  localparam int IDX_W = 7;
  localparam int SEL_W = 3;

  localparam logic [ADDR_W-1:0] CHAN_STRIDE = 10'h058;
  localparam logic [ADDR_W-1:0] CHAN_LAST = 10'h2b8;
  localparam logic [ADDR_W-1:0] GLB_BASE = 10'h2c0;
  localparam logic [ADDR_W-1:0] GLB_LAST = 10'h358;
  localparam logic [ADDR_W-1:0] STATUSINT_ADDR = 10'h360;
  localparam logic [ADDR_W-1:0] DMACFG_ADDR = 10'h398;
  localparam logic [ADDR_W-1:0] CHEN_ADDR = 10'h3a0;

  // Interrupt set order within each global register group.
  localparam logic [SEL_W-1:0] SET_TFR = 3'd0;
  localparam logic [SEL_W-1:0] SET_BLOCK = 3'd1;
  localparam logic [SEL_W-1:0] SET_SRC = 3'd2;
  localparam logic [SEL_W-1:0] SET_DST = 3'd3;
  localparam logic [SEL_W-1:0] SET_ERR = 3'd4;

  typedef enum logic [3:0] {
    K_NONE,
    K_CHAN,
    K_RAW,
    K_STAT,
    K_MASK,
    K_CLR,
    K_SINT,
    K_CFG,
    K_CHEN
  } acc_kind_t;

  typedef struct packed {
    acc_kind_t          kind;
    logic [SEL_W-1:0]   set;
    logic [IDX_W-1:0]   idx;
  } dec_t;

endpackage

### design/dmacrb_decode.sv
`timescale 1ns / 1ps

module dmacrb_decode #(
  parameter int CHANNELS = dmacrb_pkg::CHANNELS_DEF
) (
  input  logic [dmacrb_pkg::ADDR_W-1:0] address,
  output dmacrb_pkg::dec_t              dec
);
  import dmacrb_pkg::*;

  logic [CH_W-1:0]   ch;
  logic [ADDR_W-1:0] rem;
  logic [4:0]        slot_hit;
  logic [4:0]        gnum;
  logic [1:0]        grp;
  logic [SEL_W-1:0]  setk;

  function automatic logic [4:0] slot_of(input logic [6:0] off);
    logic [4:0] r;
    case (off)
      7'h00: r = {1'b1, 4'd0};
      7'h08: r = {1'b1, 4'd1};
      7'h10: r = {1'b1, 4'd2};
      7'h18: r = {1'b1, 4'd3};
      7'h1c: r = {1'b1, 4'd4};
      7'h20: r = {1'b1, 4'd5};
      7'h28: r = {1'b1, 4'd6};
      7'h30: r = {1'b1, 4'd7};
      7'h38: r = {1'b1, 4'd8};
      7'h40: r = {1'b1, 4'd9};
      7'h44: r = {1'b1, 4'd10};
      7'h48: r = {1'b1, 4'd11};
      7'h50: r = {1'b1, 4'd12};
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  always_comb begin
    // Channel number from a compare ladder against multiples of the stride.
    ch = '0;
    for (int i = 1; i < CHAN_WINDOW_SLOTS; i++) begin
      if (address >= ADDR_W'(i * int'(CHAN_STRIDE))) ch = CH_W'(i);
    end
    rem = address - ADDR_W'(ch) * CHAN_STRIDE;
    slot_hit = slot_of(rem[6:0]);

    // Global registers come in four groups of five, eight bytes apart.
    gnum = 5'((address - GLB_BASE) >> 3);
    grp = 2'(gnum >= 5'd5) + 2'(gnum >= 5'd10) + 2'(gnum >= 5'd15);
    setk = SEL_W'(gnum - 5'(grp) * 5'd5);

    dec.kind = K_NONE;
    dec.set = setk;
    dec.idx = IDX_W'(ch) * IDX_W'(REGS_PER_CHAN) + IDX_W'(slot_hit[3:0]);

    if (address <= CHAN_LAST) begin
      if (slot_hit[4] && ({1'b0, ch} < (CH_W + 1)'(CHANNELS))) dec.kind = K_CHAN;
    end else if (address >= GLB_BASE && address <= GLB_LAST && address[2:0] == 3'b000) begin
      unique case (grp)
        2'd0: dec.kind = K_RAW;
        2'd1: dec.kind = K_STAT;
        2'd2: dec.kind = K_MASK;
        2'd3: dec.kind = K_CLR;
        default: dec.kind = K_NONE;
      endcase
    end else if (address == STATUSINT_ADDR) begin
      dec.kind = K_SINT;
    end else if (address == DMACFG_ADDR) begin
      dec.kind = K_CFG;
    end else if (address == CHEN_ADDR) begin
      dec.kind = K_CHEN;
    end
  end

endmodule

### design/dmacrb_chan_mem.sv
`timescale 1ns / 1ps

module dmacrb_chan_mem #(
  parameter int DEPTH = 104,
  parameter int AW = 7
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          we,
  input  logic [AW-1:0]                 waddr,
  input  logic [dmacrb_pkg::DATA_W-1:0] wdata,
  input  logic                          re,
  input  logic [AW-1:0]                 raddr,
  output logic [dmacrb_pkg::DATA_W-1:0] rdata
);
  import dmacrb_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  vld_r;
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // An entry never written reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[waddr] <= 1'b1;
    end
  end

  // A write landing in the same cycle as the read is forwarded.
  always_ff @(posedge clk) begin
    if (re) begin
      if (we && waddr == raddr) rdata_r <= wdata;
      else if (vld_r[raddr]) rdata_r <= mem[raddr];
      else rdata_r <= '0;
    end
  end

  assign rdata = rdata_r;

endmodule

### design/dmacrb_intr.sv
`timescale 1ns / 1ps

module dmacrb_intr #(
  parameter int CHANNELS = dmacrb_pkg::CHANNELS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           fire,
  input  logic                           wr,
  input  dmacrb_pkg::dec_t               dec,
  input  logic [dmacrb_pkg::DATA_W-1:0]  wdata,
  input  logic [dmacrb_pkg::SET_W-1:0]   faults,
  output logic [dmacrb_pkg::DATA_W-1:0]  rdata,
  output logic [dmacrb_pkg::NUM_SETS-1:0] status_nxt
);
  import dmacrb_pkg::*;

  localparam logic [SET_W-1:0] ChanMask = SET_W'((16'd1 << CHANNELS) - 16'd1);

  logic [SET_W-1:0]    raw_r [NUM_SETS];
  logic [SET_W-1:0]    raw_nxt [NUM_SETS];
  logic [SET_W-1:0]    mask_r [NUM_SETS];
  logic [SET_W-1:0]    mask_nxt [NUM_SETS];
  logic                ctl_en_r;
  logic                ctl_en_nxt;
  logic [NUM_SETS-1:0] status_cur;
  logic [SET_W-1:0]    start;
  logic [SET_W-1:0]    wr_en;

  always_comb begin
    for (int k = 0; k < NUM_SETS; k++) begin
      status_cur[k] = |(raw_r[k] & mask_r[k]);
    end

    raw_nxt = raw_r;
    mask_nxt = mask_r;
    ctl_en_nxt = ctl_en_r;
    rdata = '0;
    start = wdata[7:0] & wdata[15:8] & ChanMask;
    wr_en = wdata[15:8];

    unique case (dec.kind)
      K_RAW: begin
        if (!wr) rdata = DATA_W'(raw_r[dec.set]);
      end
      K_STAT: begin
        if (!wr) rdata = DATA_W'(raw_r[dec.set] & mask_r[dec.set]);
      end
      K_MASK: begin
        if (wr) mask_nxt[dec.set] = (mask_r[dec.set] & ~wr_en) | (wdata[7:0] & wr_en);
        else rdata = DATA_W'(mask_r[dec.set]);
      end
      K_CLR: begin
        if (wr) raw_nxt[dec.set] = raw_r[dec.set] & ~wdata[7:0];
      end
      K_SINT: begin
        if (!wr) rdata = DATA_W'(status_cur);
      end
      K_CFG: begin
        if (wr) ctl_en_nxt = wdata[0];
        else rdata = DATA_W'(ctl_en_r);
      end
      K_CHEN: begin
        // Started channels complete at once and read back as disabled.
        if (wr) begin
          raw_nxt[SET_TFR] = raw_r[SET_TFR] | start;
          raw_nxt[SET_BLOCK] = raw_r[SET_BLOCK] | start;
          raw_nxt[SET_SRC] = raw_r[SET_SRC] | start;
          raw_nxt[SET_DST] = raw_r[SET_DST] | start;
          raw_nxt[SET_ERR] = raw_r[SET_ERR] | (start & faults);
        end
      end
      default: begin
      end
    endcase

    for (int k = 0; k < NUM_SETS; k++) begin
      status_nxt[k] = |(raw_nxt[k] & mask_nxt[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_SETS; k++) begin
        raw_r[k] <= '0;
        mask_r[k] <= '0;
      end
      ctl_en_r <= 1'b0;
    end else if (fire) begin
      raw_r <= raw_nxt;
      mask_r <= mask_nxt;
      ctl_en_r <= ctl_en_nxt;
    end
  end

endmodule

### design/dma_controller_register_block_unit.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// in_       input      in_valid/in_ready    action, address, write_data, transfer_faults
// out_      output     out_valid/out_ready  read_data, int_status
//
// One transaction per clock is sustained while out_ready holds high; each result passes
// through the stage-one register and then the result register. The address is decoded and
// the channel register file is read when the transaction is accepted; the update and result
// are formed when the stage-one entry moves into the result register. Synchronous reset
// clears all control state and the channel-file valid bits. A stalled result register holds
// the pipeline; in_ready drops only when both stages are full and out_ready is low.

module dma_controller_register_block_unit #(
  parameter int CHANNELS = dmacrb_pkg::CHANNELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_action,
  input  logic [dmacrb_pkg::ADDR_W-1:0]     in_address,
  input  logic [dmacrb_pkg::DATA_W-1:0]     in_write_data,
  input  logic [dmacrb_pkg::SET_W-1:0]      in_transfer_faults,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [dmacrb_pkg::DATA_W-1:0]     out_read_data,
  output logic [dmacrb_pkg::NUM_SETS-1:0]   out_int_status
);
  import dmacrb_pkg::*;

  localparam int Depth = CHANNELS * REGS_PER_CHAN;
  localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1;

  logic                s1_vld_r;
  logic                s1_wr_r;
  logic [DATA_W-1:0]   s1_wdata_r;
  logic [SET_W-1:0]    s1_faults_r;
  dec_t                s1_dec_r;
  logic                out_vld_r;
  logic [DATA_W-1:0]   out_rdata_r;
  logic [NUM_SETS-1:0] out_status_r;

  dec_t                in_dec;
  logic                in_acc;
  logic                out_take;
  logic                s1_fire;
  logic                mem_we;
  logic [DATA_W-1:0]   mem_rdata;
  logic [DATA_W-1:0]   intr_rdata;
  logic [NUM_SETS-1:0] status_nxt;

  assign out_take = !out_vld_r || out_ready;
  assign s1_fire = s1_vld_r && out_take;
  assign in_ready = !s1_vld_r || s1_fire;
  assign in_acc = in_valid && in_ready;
  assign mem_we = s1_fire && s1_wr_r && (s1_dec_r.kind == K_CHAN);

  dmacrb_decode #(
    .CHANNELS(CHANNELS)
  ) u_decode (
    .address(in_address),
    .dec    (in_dec)
  );

  dmacrb_chan_mem #(
    .DEPTH(Depth),
    .AW   (Aw)
  ) u_chan_mem (
    .clk  (clk),
    .rst_n(rst_n),
    .we   (mem_we),
    .waddr(s1_dec_r.idx[Aw-1:0]),
    .wdata(s1_wdata_r),
    .re   (in_acc),
    .raddr(in_dec.idx[Aw-1:0]),
    .rdata(mem_rdata)
  );

  dmacrb_intr #(
    .CHANNELS(CHANNELS)
  ) u_intr (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (s1_fire),
    .wr        (s1_wr_r),
    .dec       (s1_dec_r),
    .wdata     (s1_wdata_r),
    .faults    (s1_faults_r),
    .rdata     (intr_rdata),
    .status_nxt(status_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_acc) begin
      s1_vld_r <= 1'b1;
    end else if (s1_fire) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_wr_r <= in_action;
      s1_wdata_r <= in_write_data;
      s1_faults_r <= in_transfer_faults;
      s1_dec_r <= in_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_fire) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      if (s1_dec_r.kind == K_CHAN && !s1_wr_r) out_rdata_r <= mem_rdata;
      else out_rdata_r <= intr_rdata;
      out_status_r <= status_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_read_data = out_rdata_r;
  assign out_int_status = out_status_r;

endmodule

### sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import dmacrb_pkg::*;

  localparam int CHANNELS = CHANNELS_DEF;
  localparam int N_DIRECTED = 29;
  localparam int RANDOM_ITEMS = 1080;
  localparam int DRAIN_EVERY = 250;
  localparam int IDLE_BLOCK = 100;
  localparam int MAX_REPORTS = 10;
  localparam int WATCHDOG_LIMIT = 500;
  localparam int TAIL_CYCLES = 8;

  localparam logic ACT_READ = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  // Channel register offsets inside one channel's window.
  localparam logic [ADDR_W-1:0] OFF_SAR = 10'h000;
  localparam logic [ADDR_W-1:0] OFF_DAR = 10'h008;
  localparam logic [ADDR_W-1:0] OFF_LLP = 10'h010;
  localparam logic [ADDR_W-1:0] OFF_CTL_LO = 10'h018;
  localparam logic [ADDR_W-1:0] OFF_CTL_HI = 10'h01c;
  localparam logic [ADDR_W-1:0] OFF_SSTAT = 10'h020;
  localparam logic [ADDR_W-1:0] OFF_DSTAT = 10'h028;
  localparam logic [ADDR_W-1:0] OFF_SSTATAR = 10'h030;
  localparam logic [ADDR_W-1:0] OFF_DSTATAR = 10'h038;
  localparam logic [ADDR_W-1:0] OFF_CFG_LO = 10'h040;
  localparam logic [ADDR_W-1:0] OFF_CFG_HI = 10'h044;
  localparam logic [ADDR_W-1:0] OFF_SGR = 10'h048;
  localparam logic [ADDR_W-1:0] OFF_DSR = 10'h050;
  localparam logic [ADDR_W-1:0] CHAN_OFFS [0:REGS_PER_CHAN-1] = '{
    OFF_SAR, OFF_DAR, OFF_LLP, OFF_CTL_LO, OFF_CTL_HI, OFF_SSTAT, OFF_DSTAT,
    OFF_SSTATAR, OFF_DSTATAR, OFF_CFG_LO, OFF_CFG_HI, OFF_SGR, OFF_DSR
  };

  // Global register groups, five sets each, eight bytes apart.
  localparam int GRP_RAW = 0;
  localparam int GRP_STAT = 1;
  localparam int GRP_MASK = 2;
  localparam int GRP_CLR = 3;

  localparam logic [ADDR_W-1:0] ADDR_RAW_TFR = 10'h2c0;
  localparam logic [ADDR_W-1:0] ADDR_RAW_ERR = 10'h2e0;
  localparam logic [ADDR_W-1:0] ADDR_STAT_ERR = 10'h308;
  localparam logic [ADDR_W-1:0] ADDR_MASK_TFR = 10'h310;
  localparam logic [ADDR_W-1:0] ADDR_MASK_BLOCK = 10'h318;
  localparam logic [ADDR_W-1:0] ADDR_MASK_ERR = 10'h330;
  localparam logic [ADDR_W-1:0] ADDR_CLR_TFR = 10'h338;
  localparam logic [ADDR_W-1:0] ADDR_CLR_ERR = 10'h358;
  // Addresses that decode to nothing.
  localparam logic [ADDR_W-1:0] ADDR_UNLISTED_OFF = 10'h004;
  localparam logic [ADDR_W-1:0] ADDR_WINDOW_GAP = 10'h2bc;
  localparam logic [ADDR_W-1:0] ADDR_GLB_MISALIGNED = 10'h2c4;
  localparam logic [ADDR_W-1:0] ADDR_TOP = 10'h3ff;

  localparam logic [SET_W-1:0] CHAN_MASK = SET_W'((1 << CHANNELS) - 1);

  typedef struct packed {
    logic [DATA_W-1:0]   rd;
    logic [NUM_SETS-1:0] st;
  } access_result_t;

  typedef struct packed {
    logic                act;
    logic [ADDR_W-1:0]   addr;
    logic [DATA_W-1:0]   wd;
    logic [SET_W-1:0]    flt;
    logic                fixed;
    access_result_t      res;
  } dir_row_t;

  localparam access_result_t ZERO_RES = '0;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic                in_action;
  logic [ADDR_W-1:0]   in_address;
  logic [DATA_W-1:0]   in_write_data;
  logic [SET_W-1:0]    in_transfer_faults;
  logic                out_valid;
  logic                out_ready;
  logic [DATA_W-1:0]   out_read_data;
  logic [NUM_SETS-1:0] out_int_status;

  // Typed-in expectation that travels with the current transaction.
  logic                row_has_expect;
  access_result_t      row_expect;

  // Shadow of the register block.
  logic [DATA_W-1:0]   chan_file [0:CHANNELS*REGS_PER_CHAN-1];
  logic [SET_W-1:0]    raw_bits [0:NUM_SETS-1];
  logic [SET_W-1:0]    irq_mask [0:NUM_SETS-1];
  logic                ctrl_enable;

  access_result_t      pending_results [$];
  access_result_t      got_res;
  access_result_t      want_res;
  access_result_t      pred_res;
  int                  mismatch_cnt;
  int                  idle_cycles;
  bit                  idle_on;
  dir_row_t            directed_rows [0:N_DIRECTED-1];

  dma_controller_register_block_unit #(
    .CHANNELS(CHANNELS)
  ) u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_action          (in_action),
    .in_address         (in_address),
    .in_write_data      (in_write_data),
    .in_transfer_faults (in_transfer_faults),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_read_data      (out_read_data),
    .out_int_status     (out_int_status)
  );

  always #2 clk = ~clk;

  function automatic dec_t decode_address(input logic [ADDR_W-1:0] addr);
    dec_t d;
    int   ch;
    int   off;
    int   n;
    d = '{kind: K_NONE, set: '0, idx: '0};
    if (addr <= CHAN_LAST) begin
      ch = int'(addr / CHAN_STRIDE);
      off = int'(addr % CHAN_STRIDE);
      for (int s = 0; s < REGS_PER_CHAN; s++) begin
        if (CHAN_OFFS[s] == off && ch < CHANNELS) begin
          d.kind = K_CHAN;
          d.idx = IDX_W'(ch * REGS_PER_CHAN + s);
        end
      end
    end else if (addr >= GLB_BASE && addr <= GLB_LAST && addr[2:0] == 3'b000) begin
      n = int'((addr - GLB_BASE) >> 3);
      d.set = SEL_W'(n % NUM_SETS);
      case (n / NUM_SETS)
        GRP_RAW:  d.kind = K_RAW;
        GRP_STAT: d.kind = K_STAT;
        GRP_MASK: d.kind = K_MASK;
        default:  d.kind = K_CLR;
      endcase
    end else if (addr == STATUSINT_ADDR) begin
      d.kind = K_SINT;
    end else if (addr == DMACFG_ADDR) begin
      d.kind = K_CFG;
    end else if (addr == CHEN_ADDR) begin
      d.kind = K_CHEN;
    end
    return d;
  endfunction

  function automatic logic [NUM_SETS-1:0] interrupt_summary();
    logic [NUM_SETS-1:0] st;
    for (int k = 0; k < NUM_SETS; k++) st[k] = |(raw_bits[k] & irq_mask[k]);
    return st;
  endfunction

  task automatic predict_access(input logic act, input logic [ADDR_W-1:0] addr,
                                input logic [DATA_W-1:0] wd, input logic [SET_W-1:0] flt,
                                output access_result_t res);
    dec_t              d;
    logic [SET_W-1:0]  start;
    logic [DATA_W-1:0] rd;
    d = decode_address(addr);
    rd = '0;
    case (d.kind)
      K_CHAN: begin
        if (act == ACT_WRITE) chan_file[d.idx] = wd;
        else rd = chan_file[d.idx];
      end
      K_RAW: begin
        if (act == ACT_READ) rd = DATA_W'(raw_bits[d.set]);
      end
      K_STAT: begin
        if (act == ACT_READ) rd = DATA_W'(raw_bits[d.set] & irq_mask[d.set]);
      end
      K_MASK: begin
        // Bits 15:8 select which mask bits take the value in bits 7:0.
        if (act == ACT_WRITE)
          irq_mask[d.set] = (irq_mask[d.set] & ~wd[15:8]) | (wd[7:0] & wd[15:8]);
        else
          rd = DATA_W'(irq_mask[d.set]);
      end
      K_CLR: begin
        if (act == ACT_WRITE) raw_bits[d.set] = raw_bits[d.set] & ~wd[SET_W-1:0];
      end
      K_SINT: begin
        if (act == ACT_READ) rd = DATA_W'(interrupt_summary());
      end
      K_CFG: begin
        if (act == ACT_WRITE) ctrl_enable = wd[0];
        else rd = DATA_W'(ctrl_enable);
      end
      K_CHEN: begin
        // Started channels finish at once and always read back as disabled.
        if (act == ACT_WRITE) begin
          start = wd[7:0] & wd[15:8] & CHAN_MASK;
          raw_bits[SET_TFR] = raw_bits[SET_TFR] | start;
          raw_bits[SET_BLOCK] = raw_bits[SET_BLOCK] | start;
          raw_bits[SET_SRC] = raw_bits[SET_SRC] | start;
          raw_bits[SET_DST] = raw_bits[SET_DST] | start;
          raw_bits[SET_ERR] = raw_bits[SET_ERR] | (start & flt);
        end
      end
      default: ;
    endcase
    res.rd = rd;
    res.st = interrupt_summary();
  endtask

  // Holds one transaction on the bus until it is accepted.
  task automatic drive_item(input logic act, input logic [ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] wd, input logic [SET_W-1:0] flt,
                            input logic fixed, input access_result_t res);
    int gap;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_address <= addr;
    in_write_data <= wd;
    in_transfer_faults <= flt;
    row_has_expect <= fixed;
    row_expect <= res;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got_res.rd = out_read_data;
        got_res.st = out_int_status;
        if (pending_results.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("%0t: result with nothing pending: read_data %h int_status %h",
                     $realtime, got_res.rd, got_res.st);
        end else begin
          want_res = pending_results.pop_front();
          if (got_res.rd !== want_res.rd || got_res.st !== want_res.st) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS)
              $display("%0t: mismatch read_data exp %h got %h, int_status exp %h got %h",
                       $realtime, want_res.rd, got_res.rd, want_res.st, got_res.st);
          end
        end
      end
      if (in_valid && in_ready) begin
        predict_access(in_action, in_address, in_write_data, in_transfer_faults, pred_res);
        pending_results.push_back(row_has_expect ? row_expect : pred_res);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Result side: while idle_on is set, hold out_ready low for a random stall before each result.
  initial begin
    int stall;
    out_ready = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = idle_on ? $urandom_range(0, 7) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    logic              act;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wd;
    logic [SET_W-1:0]  flt;
    int                pick;
    int                ch;
    int                slot;
    int                grp;
    int                setn;

    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = ACT_READ;
    in_address = '0;
    in_write_data = '0;
    in_transfer_faults = '0;
    row_has_expect = 1'b0;
    row_expect = ZERO_RES;
    ctrl_enable = 1'b0;
    for (int i = 0; i < CHANNELS * REGS_PER_CHAN; i++) chan_file[i] = '0;
    for (int k = 0; k < NUM_SETS; k++) begin
      raw_bits[k] = '0;
      irq_mask[k] = '0;
    end
    mismatch_cnt = 0;
    idle_cycles = 0;
    idle_on = 1'b1;

    directed_rows = '{
      '{ACT_READ,  OFF_SAR,             32'h0,        8'h00, 1'b1, ZERO_RES},
      '{ACT_READ,  CHAN_LAST,           32'h0,        8'hff, 1'b1, ZERO_RES},
      '{ACT_WRITE, OFF_SAR,             32'hffffffff, 8'h00, 1'b1, ZERO_RES},
      '{ACT_READ,  OFF_SAR,             32'h0,        8'h00, 1'b1, '{32'hffffffff, 5'h00}},
      '{ACT_WRITE, CHAN_LAST,           32'ha5a5a5a5, 8'h00, 1'b1, ZERO_RES},
      '{ACT_READ,  CHAN_LAST,           32'h0,        8'h00, 1'b1, '{32'ha5a5a5a5, 5'h00}},
      '{ACT_READ,  ADDR_UNLISTED_OFF,   32'h0,        8'h00, 1'b1, ZERO_RES},
      '{ACT_WRITE, ADDR_TOP,            32'hffffffff, 8'hff, 1'b1, ZERO_RES},
      '{ACT_READ,  ADDR_TOP,            32'h0,        8'h00, 1'b1, ZERO_RES},
      '{ACT_READ,  ADDR_WINDOW_GAP,     32'h0,        8'h00, 1'b1, ZERO_RES},
      '{ACT_WRITE, ADDR_MASK_TFR,       32'h0000ffff, 8'h00, 1'b1, ZERO_RES},
      '{ACT_WRITE, ADDR_MASK_ERR,       32'h0000ff0f, 8'h00, 1'b1, ZERO_RES},
      '{ACT_WRITE, ADDR_MASK_BLOCK,     32'h0000aa55, 8'h00, 1'b0, ZERO_RES},
      '{ACT_WRITE, CHEN_ADDR,           32'h0000ffff, 8'haa, 1'b0, ZERO_RES},
      '{ACT_READ,  ADDR_RAW_TFR,        32'h0,        8'h00, 1'b0, ZERO_RES},
      '{ACT_READ,  ADDR_STAT_ERR,       32'h0,        8'h00, 1'b0, ZERO_RES},
      '{ACT_READ,  STATUSINT_ADDR,      32'h0,        8'h00, 1'b0, ZERO_RES},
      '{ACT_READ,  CHEN_ADDR,           32'h0,        8'h00, 1'b0, ZERO_RES},
      '{ACT_READ,  ADDR_CLR_TFR,        32'h0,        8'h00, 1'b0, ZERO_RES},
      '{ACT_WRITE, ADDR_RAW_ERR,        32'hffffffff, 8'h00, 1'b0, ZERO_RES},
      '{ACT_WRITE, ADDR_MASK_TFR,       32'h00000f00, 8'h00, 1'b0, ZERO_RES},
      '{ACT_READ,  ADDR_MASK_TFR,       32'h0,        8'h00, 1'b0, ZERO_RES},
      '{ACT_WRITE, ADDR_CLR_ERR,        32'hffffffff, 8'h00, 1'b0, ZERO_RES},
      '{ACT_WRITE, ADDR_CLR_TFR,        32'h00000001, 8'h00, 1'b0, ZERO_RES},
      '{ACT_WRITE, DMACFG_ADDR,         32'hffffffff, 8'h00, 1'b0, ZERO_RES},
      '{ACT_READ,  DMACFG_ADDR,         32'h0,        8'h00, 1'b0, ZERO_RES},
      '{ACT_WRITE, CHEN_ADDR,           32'h00ff00ff, 8'hff, 1'b0, ZERO_RES},
      '{ACT_READ,  ADDR_GLB_MISALIGNED, 32'h0,        8'h00, 1'b0, ZERO_RES},
      '{ACT_WRITE, DMACFG_ADDR,         32'h0,        8'h00, 1'b0, ZERO_RES}
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r])
      drive_item(directed_rows[r].act, directed_rows[r].addr, directed_rows[r].wd,
                 directed_rows[r].flt, directed_rows[r].fixed, directed_rows[r].res);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // Every third block of transactions runs with neither side idling.
      if (i % IDLE_BLOCK == 0) idle_on = ((i / IDLE_BLOCK) % 3 != 2);
      if (i % DRAIN_EVERY == 0) begin
        in_valid <= 1'b0;
        do @(negedge clk); while (pending_results.size() != 0);
        @(posedge clk);
      end
      pick = $urandom_range(0, 99);
      act = 1'($urandom_range(0, 1));
      wd = $urandom;
      flt = SET_W'($urandom_range(0, 255));
      if (pick < 35) begin
        ch = $urandom_range(0, CHANNELS - 1);
        slot = $urandom_range(0, REGS_PER_CHAN - 1);
        addr = ADDR_W'(ch * CHAN_STRIDE + CHAN_OFFS[slot]);
      end else if (pick < 60) begin
        grp = $urandom_range(GRP_RAW, GRP_CLR);
        setn = $urandom_range(0, NUM_SETS - 1);
        addr = GLB_BASE + ADDR_W'((grp * NUM_SETS + setn) * 8);
        // Single-bit clears let raw bits survive long enough to be seen.
        if (grp == GRP_CLR && $urandom_range(0, 1) == 1)
          wd = DATA_W'(1) << $urandom_range(0, SET_W - 1);
      end else if (pick < 66) begin
        addr = STATUSINT_ADDR;
      end else if (pick < 74) begin
        addr = DMACFG_ADDR;
      end else if (pick < 88) begin
        addr = CHEN_ADDR;
        act = ($urandom_range(0, 3) != 0) ? ACT_WRITE : ACT_READ;
      end else begin
        addr = ADDR_W'($urandom_range(0, (1 << ADDR_W) - 1));
      end
      drive_item(act, addr, wd, flt, 1'b0, ZERO_RES);
    end

    in_valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && pending_results.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
